// ===== sv/ttf_pkg.sv =====
// Package for the tether tension force unit: field widths, op codes,
// register indices and the saturation helper. No dependencies.
package ttf_pkg;

    localparam int unsigned WORD_W          = 32;
    localparam int unsigned LEN_W           = 31;
    localparam int unsigned IN_TDATA_W      = 128;
    localparam int unsigned OUT_TDATA_W     = 96;
    localparam int unsigned AXIAL_STIFFNESS = 200;

    typedef enum logic [1:0] {
        OP_POSITION = 2'd0,
        OP_QUAT     = 2'd1,
        OP_VELOCITY = 2'd2,
        OP_COMPUTE  = 2'd3
    } t_op;

    localparam logic [2:0] REG_ANCHOR_X = 3'd0;
    localparam logic [2:0] REG_ANCHOR_Y = 3'd1;
    localparam logic [2:0] REG_ANCHOR_Z = 3'd2;
    localparam logic [2:0] REG_ATTACH_X = 3'd3;
    localparam logic [2:0] REG_ATTACH_Y = 3'd4;
    localparam logic [2:0] REG_ATTACH_Z = 3'd5;
    localparam logic [2:0] REG_IDLE     = 3'd6;
    localparam logic [2:0] REG_SLACK    = 3'd7;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/tether_tension_force_unit.sv =====
// Tether tension force unit: sequencer around one shared multiplier with
// an iterative divider and square root. Depends on ttf_pkg.
//
// Input words arrive on the slave stream; tuser carries the op code. Ops for
// position, quaternion and linear velocity are registered on acceptance and
// give no output word. An op carrying angular velocity and mass starts the
// computation; the block is not ready until the sequencer has finished.
// One 33 by 33 bit multiplier is used at most once per step; a restoring
// divider gives 64-bit quotients and the square root is taken bit by bit.
// The divisions take most of the time of a compute word: six when the
// tether is slack and seven when it is taut. The input is ready again when
// the output word appears, so a new compute word can be accepted then.
// The result is placed in an output register on the master stream. If the
// receiver stalls, staging words are still accepted, and a following compute
// word runs until its result is ready, then waits for the register to free.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block itself does not enforce this. Reset clears the
// held state, the registers to their defaults, and the output valid flag.
module tether_tension_force_unit
    import ttf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // comp_a [31:0], comp_b [63:32], comp_c [95:64], comp_d [127:96]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op [1:0]
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // force_x [31:0], force_y [63:32], force_z [95:64]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // taut [0], degenerate [1]
    output logic [1:0]             o_m_axis_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [2:0]             i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SQRT, S_OUT} t_state;

    localparam logic [5:0] STEP_FORCE = 6'd50;

    t_state r_state;
    logic [5:0] r_step;
    logic [5:0] r_cnt;

    logic signed [31:0] r_anc [3];
    logic signed [31:0] r_att [3];
    logic [LEN_W-1:0] r_idle, r_slack;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_om [3];
    logic signed [31:0] r_mass;

    logic signed [31:0] r_uu, r_s, r_c0, r_uv, r_t0, r_t1, r_t2;
    logic signed [31:0] r_cu [3];
    logic signed [31:0] r_rb [3];
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_vq [3];
    logic signed [31:0] r_k, r_xd, r_dmp, r_ten;
    logic signed [31:0] r_f [3];
    logic [LEN_W-1:0] r_len, r_x;
    logic signed [51:0] r_acc, r_dacc;
    logic [63:0] r_sq;
    logic r_taut, r_degen;

    logic signed [65:0] r_prod;
    logic signed [32:0] ma, mb;
    logic signed [31:0] mq;

    logic [63:0] r_dnum;
    logic [32:0] r_drem;
    logic [31:0] r_dden;
    logic r_dneg;
    logic signed [31:0] r_dq;

    logic [63:0] r_sn, r_sr, r_sbit;
    logic [32:0] r_root;

    logic r_mvalid;
    logic [OUT_TDATA_W-1:0] r_mdata;
    logic [1:0] r_muser;

    logic s_fire;
    logic [32:0] rem_sh, rem_nx;
    logic dge;
    logic [63:0] q_nx;
    logic [63:0] trial, sr_nx, sn_nx;
    logic sge;
    logic [LEN_W-1:0] len_c;
    logic signed [51:0] mq52;
    logic signed [51:0] dot_mag;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? (~v + 32'd1) : v;
        return res;
    endfunction

    function automatic logic signed [31:0] divsat(input logic [63:0] q, input logic neg,
                                                  input logic den_zero);
        logic signed [31:0] res;
        if (den_zero) begin
            res = '0;
        end else if (!neg) begin
            res = (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
        end else begin
            res = (q > 64'h80000000) ? 32'sh80000000 : (~q[31:0] + 32'd1);
        end
        return res;
    endfunction

    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;
    assign o_m_axis_tuser  = r_muser;

    assign mq   = sat32(66'(r_prod >>> 16));
    assign mq52 = 52'(mq);

    assign rem_sh = {r_drem[31:0], r_dnum[63]};
    assign dge    = rem_sh >= {1'b0, r_dden};
    assign rem_nx = dge ? (rem_sh - {1'b0, r_dden}) : rem_sh;
    assign q_nx   = {r_dnum[62:0], dge};

    assign trial = r_sr + r_sbit;
    assign sge   = r_sn >= trial;
    assign sr_nx = sge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);
    assign sn_nx = sge ? (r_sn - trial) : r_sn;

    assign len_c   = (r_root > 33'h07FFFFFFF) ? {LEN_W{1'b1}} : r_root[LEN_W-1:0];
    assign dot_mag = r_dacc[51] ? -r_dacc : r_dacc;

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_step)
            6'd0:  begin ma = 33'(r_q[1]); mb = 33'(r_q[1]); end
            6'd1:  begin ma = 33'(r_q[2]); mb = 33'(r_q[2]); end
            6'd2:  begin ma = 33'(r_q[3]); mb = 33'(r_q[3]); end
            6'd3:  begin ma = 33'(r_q[0]); mb = 33'(r_q[0]); end
            6'd4:  begin ma = 33'(r_q[1]); mb = 33'(r_att[0]); end
            6'd5:  begin ma = 33'(r_q[2]); mb = 33'(r_att[1]); end
            6'd6:  begin ma = 33'(r_q[3]); mb = 33'(r_att[2]); end
            6'd7:  begin ma = 33'(r_q[2]); mb = 33'(r_att[2]); end
            6'd8:  begin ma = 33'(r_q[3]); mb = 33'(r_att[1]); end
            6'd9:  begin ma = 33'(r_q[3]); mb = 33'(r_att[0]); end
            6'd10: begin ma = 33'(r_q[1]); mb = 33'(r_att[2]); end
            6'd11: begin ma = 33'(r_q[1]); mb = 33'(r_att[1]); end
            6'd12: begin ma = 33'(r_q[2]); mb = 33'(r_att[0]); end
            6'd13: begin ma = 33'(r_c0);   mb = 33'(r_att[0]); end
            6'd14: begin ma = 33'(r_uv);   mb = 33'(r_q[1]); end
            6'd15: begin ma = 33'(r_q[0]); mb = 33'(r_cu[0]); end
            6'd16: begin ma = 33'(r_c0);   mb = 33'(r_att[1]); end
            6'd17: begin ma = 33'(r_uv);   mb = 33'(r_q[2]); end
            6'd18: begin ma = 33'(r_q[0]); mb = 33'(r_cu[1]); end
            6'd19: begin ma = 33'(r_c0);   mb = 33'(r_att[2]); end
            6'd20: begin ma = 33'(r_uv);   mb = 33'(r_q[3]); end
            6'd21: begin ma = 33'(r_q[0]); mb = 33'(r_cu[2]); end
            6'd28: begin ma = 33'(r_p[0]); mb = 33'(r_p[0]); end
            6'd29: begin ma = 33'(r_p[1]); mb = 33'(r_p[1]); end
            6'd30: begin ma = 33'(r_p[2]); mb = 33'(r_p[2]); end
            6'd34: begin ma = 33'(r_om[1]); mb = 33'(r_rb[2]); end
            6'd35: begin ma = 33'(r_om[2]); mb = 33'(r_rb[1]); end
            6'd36: begin ma = 33'(r_om[2]); mb = 33'(r_rb[0]); end
            6'd37: begin ma = 33'(r_om[0]); mb = 33'(r_rb[2]); end
            6'd38: begin ma = 33'(r_om[0]); mb = 33'(r_rb[1]); end
            6'd39: begin ma = 33'(r_om[1]); mb = 33'(r_rb[0]); end
            6'd40: begin ma = 33'(r_vq[0]); mb = 33'(r_p[0]); end
            6'd41: begin ma = 33'(r_vq[1]); mb = 33'(r_p[1]); end
            6'd42: begin ma = 33'(r_vq[2]); mb = 33'(r_p[2]); end
            6'd43: begin ma = 33'(AXIAL_STIFFNESS); mb = {2'b00, r_slack}; end
            6'd45: begin ma = r_mass[31] ? 33'sd0 : 33'(r_mass); mb = 33'(r_k); end
            6'd47: begin ma = 33'(r_k);   mb = {2'b00, r_x}; end
            6'd48: begin ma = 33'(r_dmp); mb = 33'(r_xd); end
            6'd50: begin ma = {1'b0, mag32(r_ten)}; mb = {1'b0, mag32(r_p[0])}; end
            6'd52: begin ma = {1'b0, mag32(r_ten)}; mb = {1'b0, mag32(r_p[1])}; end
            6'd54: begin ma = {1'b0, mag32(r_ten)}; mb = {1'b0, mag32(r_p[2])}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_cnt    <= '0;
            r_mvalid <= 1'b0;
            r_anc    <= '{default: '0};
            r_att    <= '{default: '0};
            r_idle   <= 31'd65536;
            r_slack  <= 31'd327680;
            r_pos    <= '{default: '0};
            r_q      <= '{default: '0};
            r_vel    <= '{default: '0};
        end else begin
            if (i_m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_ANCHOR_X: r_anc[0] <= i_cfg_wdata;
                    REG_ANCHOR_Y: r_anc[1] <= i_cfg_wdata;
                    REG_ANCHOR_Z: r_anc[2] <= i_cfg_wdata;
                    REG_ATTACH_X: r_att[0] <= i_cfg_wdata;
                    REG_ATTACH_Y: r_att[1] <= i_cfg_wdata;
                    REG_ATTACH_Z: r_att[2] <= i_cfg_wdata;
                    REG_IDLE:     r_idle   <= i_cfg_wdata[LEN_W-1:0];
                    REG_SLACK:    r_slack  <= i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        unique case (t_op'(i_s_axis_tuser))
                            OP_POSITION: begin
                                r_pos[0] <= i_s_axis_tdata[31:0];
                                r_pos[1] <= i_s_axis_tdata[63:32];
                                r_pos[2] <= i_s_axis_tdata[95:64];
                            end
                            OP_QUAT: begin
                                r_q[0] <= i_s_axis_tdata[31:0];
                                r_q[1] <= i_s_axis_tdata[63:32];
                                r_q[2] <= i_s_axis_tdata[95:64];
                                r_q[3] <= i_s_axis_tdata[127:96];
                            end
                            OP_VELOCITY: begin
                                r_vel[0] <= i_s_axis_tdata[31:0];
                                r_vel[1] <= i_s_axis_tdata[63:32];
                                r_vel[2] <= i_s_axis_tdata[95:64];
                            end
                            OP_COMPUTE: begin
                                r_om[0] <= i_s_axis_tdata[31:0];
                                r_om[1] <= i_s_axis_tdata[63:32];
                                r_om[2] <= i_s_axis_tdata[95:64];
                                r_mass  <= i_s_axis_tdata[127:96];
                                r_taut  <= 1'b0;
                                r_degen <= 1'b0;
                                r_step  <= '0;
                                r_state <= S_MUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 6'd1;
                    unique case (r_step)
                        6'd1:  r_acc <= mq52;
                        6'd2:  r_acc <= r_acc + mq52;
                        6'd3:  r_uu  <= sat32(66'(r_acc + mq52));
                        6'd4: begin
                            r_s  <= sat32(66'(mq) + 66'(r_uu));
                            r_c0 <= sat32(66'(mq) - 66'(r_uu));
                        end
                        6'd5:  r_acc   <= mq52;
                        6'd6:  r_acc   <= r_acc + mq52;
                        6'd7:  r_uv    <= sat32(66'(r_acc + mq52));
                        6'd8:  r_acc   <= mq52;
                        6'd9:  r_cu[0] <= sat32(66'(r_acc - mq52));
                        6'd10: r_acc   <= mq52;
                        6'd11: r_cu[1] <= sat32(66'(r_acc - mq52));
                        6'd12: r_acc   <= mq52;
                        6'd13: r_cu[2] <= sat32(66'(r_acc - mq52));
                        6'd14, 6'd17, 6'd20: r_acc <= mq52;
                        6'd15, 6'd18, 6'd21: r_acc <= r_acc + (mq52 <<< 1);
                        6'd16: r_t0 <= sat32(66'(r_acc + (mq52 <<< 1)));
                        6'd19: r_t1 <= sat32(66'(r_acc + (mq52 <<< 1)));
                        6'd22: r_t2 <= sat32(66'(r_acc + (mq52 <<< 1)));
                        6'd23, 6'd24, 6'd25: begin
                            if (r_step == 6'd24) r_rb[0] <= r_dq;
                            if (r_step == 6'd25) r_rb[1] <= r_dq;
                            r_dnum  <= {16'd0, mag32((r_step == 6'd23) ? r_t0 :
                                        (r_step == 6'd24) ? r_t1 : r_t2), 16'd0};
                            r_dneg  <= (r_step == 6'd23) ? r_t0[31] :
                                       (r_step == 6'd24) ? r_t1[31] : r_t2[31];
                            r_dden  <= r_s[31] ? 32'd0 : r_s;
                            r_drem  <= '0;
                            r_cnt   <= '0;
                            r_step  <= r_step;
                            r_state <= S_DIV;
                        end
                        6'd26: r_rb[2] <= r_dq;
                        6'd27: begin
                            for (int i = 0; i < 3; i++) begin
                                r_p[i] <= sat32(66'(r_pos[i]) - 66'(r_anc[i]) + 66'(r_rb[i]));
                            end
                        end
                        6'd29: r_sq <= r_prod[63:0];
                        6'd30: r_sq <= r_sq + r_prod[63:0];
                        6'd31, 6'd46: begin
                            r_sn    <= (r_step == 6'd31) ? (r_sq + r_prod[63:0]) :
                                       r_prod[63:0];
                            r_sr    <= '0;
                            r_sbit  <= 64'h4000000000000000;
                            r_cnt   <= '0;
                            r_step  <= r_step;
                            r_state <= S_SQRT;
                        end
                        6'd32: begin
                            r_len <= len_c;
                            if (len_c == '0) begin
                                r_f     <= '{default: '0};
                                r_degen <= 1'b1;
                                r_state <= S_OUT;
                            end else if (len_c > r_slack) begin
                                r_taut <= 1'b1;
                                r_x    <= len_c - r_slack;
                            end else begin
                                r_ten  <= {1'b0, r_idle};
                                r_step <= STEP_FORCE;
                            end
                        end
                        6'd35, 6'd37, 6'd39: begin
                            r_acc <= 52'((r_step == 6'd35) ? r_vel[0] :
                                         (r_step == 6'd37) ? r_vel[1] : r_vel[2]) + mq52;
                        end
                        6'd36: r_vq[0] <= sat32(66'(r_acc - mq52));
                        6'd38: r_vq[1] <= sat32(66'(r_acc - mq52));
                        6'd40: r_vq[2] <= sat32(66'(r_acc - mq52));
                        6'd41: r_dacc  <= 52'(r_prod >>> 16);
                        6'd42, 6'd43: r_dacc <= r_dacc + 52'(r_prod >>> 16);
                        6'd44: begin
                            r_k     <= sat32(r_prod);
                            r_dnum  <= {dot_mag[47:0], 16'd0};
                            r_dneg  <= r_dacc[51];
                            r_dden  <= {1'b0, r_len};
                            r_drem  <= '0;
                            r_cnt   <= '0;
                            r_step  <= r_step;
                            r_state <= S_DIV;
                        end
                        6'd45: r_xd  <= r_dq;
                        6'd47: r_dmp <= sat32(66'({r_root, 1'b0}));
                        6'd48: r_acc <= mq52;
                        6'd49: r_ten <= sat32(66'(r_acc + mq52));
                        6'd51, 6'd53, 6'd55: begin
                            if (r_step == 6'd53) r_f[0] <= r_dq;
                            if (r_step == 6'd55) r_f[1] <= r_dq;
                            r_dnum  <= r_prod[63:0];
                            r_dneg  <= r_ten[31] == ((r_step == 6'd51) ? r_p[0][31] :
                                       (r_step == 6'd53) ? r_p[1][31] : r_p[2][31]);
                            r_dden  <= {1'b0, r_len};
                            r_drem  <= '0;
                            r_cnt   <= '0;
                            r_step  <= r_step;
                            r_state <= S_DIV;
                        end
                        6'd56: begin
                            r_f[2]  <= r_dq;
                            r_state <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    r_drem <= rem_nx;
                    r_dnum <= q_nx;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_dq    <= divsat(q_nx, r_dneg, r_dden == '0);
                        r_step  <= r_step + 6'd1;
                        r_state <= S_MUL;
                    end
                end
                S_SQRT: begin
                    r_sn   <= sn_nx;
                    r_sr   <= sr_nx;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_root  <= sr_nx[32:0];
                        r_step  <= r_step + 6'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_mvalid || i_m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= {r_f[2], r_f[1], r_f[0]};
                        r_muser  <= {r_degen, r_taut};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/ttf_checker.sv =====
// Port-level checker for the tether tension force unit, bound to the top
// level. Depends on ttf_pkg and tether_tension_force_unit.
module ttf_checker
    import ttf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [1:0]             i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]             o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == '0 && !o_m_axis_tuser[0])
        else $error("degenerate word carries a force or taut flag");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_COMPUTE
        |=> !o_s_axis_tready)
        else $error("ready stayed high after a compute word");

endmodule

bind tether_tension_force_unit ttf_checker u_ttf_checker (.*);
